FILE: design/ftda_pkg.sv
// Shared constants, types and the control store for the fixed-point to ASCII converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ftda_pkg;

    localparam int VALUE_W         = 56;
    localparam int FRAC_BITS       = 24;
    localparam int INT_W           = VALUE_W - FRAC_BITS;
    localparam int BCD_DIGITS      = 10;   // decimal digits of a 32-bit integer part
    localparam int MAX_INT_DIGITS  = 12;
    localparam int MAX_FRAC_DIGITS = 8;
    localparam int CFG_W           = 4;
    localparam int CHAR_W          = 8;
    localparam int DIGIT_W         = 4;
    localparam int LEN_W           = 5;    // up to 1 + 12 + 1 + 8 characters
    localparam int DPTR_W          = 4;
    localparam int PC_W            = 3;
    localparam int CNT_W           = 5;
    localparam int OP_W            = 3;
    localparam int CND_W           = 3;

    localparam logic [CNT_W-1:0] DABBLE_LAST = CNT_W'(INT_W - 1);

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    // configuration register indexes
    localparam logic REG_INT_WIDTH  = 1'b0;
    localparam logic REG_FRAC_WIDTH = 1'b1;

    // datapath operations
    localparam logic [OP_W-1:0] OP_ACCEPT = 3'd0;
    localparam logic [OP_W-1:0] OP_DABBLE = 3'd1;
    localparam logic [OP_W-1:0] OP_POINT  = 3'd2;
    localparam logic [OP_W-1:0] OP_SIGN   = 3'd3;
    localparam logic [OP_W-1:0] OP_IDIG   = 3'd4;
    localparam logic [OP_W-1:0] OP_DOT    = 3'd5;
    localparam logic [OP_W-1:0] OP_FDIG   = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd7;

    // jump conditions
    localparam logic [CND_W-1:0] CND_NEVER     = 3'd0;
    localparam logic [CND_W-1:0] CND_ALWAYS    = 3'd1;
    localparam logic [CND_W-1:0] CND_NO_ACCEPT = 3'd2;
    localparam logic [CND_W-1:0] CND_CNT_NZ    = 3'd3;
    localparam logic [CND_W-1:0] CND_DPTR_NZ   = 3'd4;
    localparam logic [CND_W-1:0] CND_FW_ZERO   = 3'd5;
    localparam logic [CND_W-1:0] CND_FRAC_MORE = 3'd6;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
    localparam logic [PC_W-1:0] PC_DABBLE = 3'd1;
    localparam logic [PC_W-1:0] PC_POINT  = 3'd2;
    localparam logic [PC_W-1:0] PC_SIGN   = 3'd3;
    localparam logic [PC_W-1:0] PC_IDIG   = 3'd4;
    localparam logic [PC_W-1:0] PC_DOT    = 3'd5;
    localparam logic [PC_W-1:0] PC_FDIG   = 3'd6;
    localparam logic [PC_W-1:0] PC_TAIL   = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CND_W-1:0] cond;
        logic [PC_W-1:0]  target;
        logic             cnt_ld;
        logic [CNT_W-1:0] cnt_val;
    } uword_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic accept;
        logic emit;
        logic last;
        logic stall;
        logic dptr_nz;
        logic frac_more;
        logic fw_zero;
    } dp_status_t;

    // Taken jump goes to target, otherwise fall through to the next step.
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] addr);
        uword_t w;
        begin
            w = '{op: OP_NOP, cond: CND_ALWAYS, target: PC_IDLE, cnt_ld: 1'b0,
                  cnt_val: '0};
            unique case (addr)
                PC_IDLE:   w = '{op: OP_ACCEPT, cond: CND_NO_ACCEPT, target: PC_IDLE,
                                 cnt_ld: 1'b1, cnt_val: DABBLE_LAST};
                PC_DABBLE: w = '{op: OP_DABBLE, cond: CND_CNT_NZ, target: PC_DABBLE,
                                 cnt_ld: 1'b0, cnt_val: '0};
                PC_POINT:  w = '{op: OP_POINT, cond: CND_NEVER, target: PC_IDLE,
                                 cnt_ld: 1'b0, cnt_val: '0};
                PC_SIGN:   w = '{op: OP_SIGN, cond: CND_NEVER, target: PC_IDLE,
                                 cnt_ld: 1'b0, cnt_val: '0};
                PC_IDIG:   w = '{op: OP_IDIG, cond: CND_DPTR_NZ, target: PC_IDIG,
                                 cnt_ld: 1'b0, cnt_val: '0};
                PC_DOT:    w = '{op: OP_DOT, cond: CND_FW_ZERO, target: PC_IDLE,
                                 cnt_ld: 1'b0, cnt_val: '0};
                PC_FDIG:   w = '{op: OP_FDIG, cond: CND_FRAC_MORE, target: PC_FDIG,
                                 cnt_ld: 1'b0, cnt_val: '0};
                PC_TAIL:   w = '{op: OP_NOP, cond: CND_ALWAYS, target: PC_IDLE,
                                 cnt_ld: 1'b0, cnt_val: '0};
            endcase
            return w;
        end
    endfunction

endpackage

FILE: design/ftda_seq.sv
// Microcode sequencer: step counter, loop counter and jump logic over the control store.
// Depends on ftda_pkg.
`timescale 1ns / 1ps

module ftda_seq
    import ftda_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  dp_status_t       status,
    output logic [OP_W-1:0]  op
);

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    uword_t           uw;
    logic             take;

    assign uw = ucode_rom(pc_reg);
    assign op = uw.op;

    always_comb begin
        unique case (uw.cond)
            CND_ALWAYS:    take = 1'b1;
            CND_NO_ACCEPT: take = !status.accept;
            CND_CNT_NZ:    take = (cnt_reg != '0);
            CND_DPTR_NZ:   take = status.dptr_nz;
            CND_FW_ZERO:   take = status.fw_zero;
            CND_FRAC_MORE: take = status.frac_more;
            default:       take = 1'b0;
        endcase
    end

    always_comb begin
        pc_next  = pc_reg;
        cnt_next = cnt_reg;
        priority if (status.stall) begin
            pc_next = pc_reg;
        end else if (status.emit && status.last) begin
            // string complete, wherever the clip fell
            pc_next = PC_IDLE;
        end else begin
            pc_next = take ? uw.target : pc_reg + PC_W'(1);
            if (uw.cnt_ld) begin
                cnt_next = uw.cnt_val;
            end else if (uw.cond == CND_CNT_NZ && cnt_reg != '0) begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= PC_IDLE;
            cnt_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/ftda_dp.sv
// Datapath: magnitude capture, binary-to-BCD shift-add-3, fraction times ten, character mux.
// Depends on ftda_pkg; driven one operation per cycle by ftda_seq, which holds the operation while the output stalls.
`timescale 1ns / 1ps

module ftda_dp
    import ftda_pkg::*;
(
    input  logic                aclk,
    input  logic [OP_W-1:0]     op,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,
    input  logic [CFG_W-1:0]    int_width,
    input  logic [CFG_W-1:0]    frac_width,
    input  logic                slot_free,
    output logic                emit,
    output logic [CHAR_W-1:0]   emit_char,
    output logic                emit_last,
    output dp_status_t          status
);

    logic                 neg_reg;
    logic [INT_W-1:0]     ipart_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [DIGIT_W-1:0]   bcd_reg [BCD_DIGITS];
    logic [CFG_W-1:0]     iw_reg;
    logic [CFG_W-1:0]     fw_reg;
    logic [CFG_W-1:0]     fcnt_reg;
    logic [DPTR_W-1:0]    dptr_reg;
    logic [LEN_W-1:0]     left_reg;

    logic                 neg_in;
    logic [VALUE_W-1:0]   mag_in;
    logic [CFG_W-1:0]     iw_c, fw_c;
    logic [LEN_W-1:0]     len_in;
    logic [DIGIT_W-1:0]   adj [BCD_DIGITS];
    logic [DIGIT_W-1:0]   bcd_shift [BCD_DIGITS];
    logic [DPTR_W-1:0]    top_idx, ndig, start_ptr;
    logic [DIGIT_W-1:0]   cur_digit;
    logic [FRAC_BITS+DIGIT_W-1:0] prod;
    logic                 accept, want;

    assign s_tready = (op == OP_ACCEPT);
    assign accept   = s_tready && s_tvalid;

    // magnitude is exact for the most negative value in an unsigned word
    assign neg_in = s_tdata[VALUE_W-1];
    assign mag_in = neg_in ? (~s_tdata + VALUE_W'(1)) : s_tdata;

    always_comb begin
        if (int_width == '0) begin
            iw_c = CFG_W'(1);
        end else if (int_width > CFG_W'(MAX_INT_DIGITS)) begin
            iw_c = CFG_W'(MAX_INT_DIGITS);
        end else begin
            iw_c = int_width;
        end
        fw_c = (frac_width > CFG_W'(MAX_FRAC_DIGITS)) ? CFG_W'(MAX_FRAC_DIGITS) : frac_width;
        len_in = LEN_W'(neg_in) + LEN_W'(iw_c)
               + ((fw_c != '0) ? (LEN_W'(fw_c) + LEN_W'(1)) : '0);
    end

    // one shift-add-3 step
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= DIGIT_W'(5)) ? bcd_reg[i] + DIGIT_W'(3) : bcd_reg[i];
        end
        bcd_shift[0] = {adj[0][DIGIT_W-2:0], ipart_reg[INT_W-1]};
        for (int i = 1; i < BCD_DIGITS; i++) begin
            bcd_shift[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
        end
    end

    // first printed position: the larger of the significant digits and the pad width
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[i] != '0) begin
                top_idx = DPTR_W'(i);
            end
        end
        ndig      = top_idx + DPTR_W'(1);
        start_ptr = (ndig > iw_reg) ? top_idx : iw_reg - DPTR_W'(1);
    end

    assign cur_digit = (dptr_reg < DPTR_W'(BCD_DIGITS)) ? bcd_reg[dptr_reg] : '0;
    assign prod = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0};

    always_comb begin
        want      = 1'b0;
        emit_char = CH_ZERO;
        unique case (op)
            OP_SIGN: begin
                want      = neg_reg;
                emit_char = CH_MINUS;
            end
            OP_IDIG: begin
                want      = 1'b1;
                emit_char = CH_ZERO + CHAR_W'(cur_digit);
            end
            OP_DOT: begin
                want      = (fw_reg != '0);
                emit_char = CH_DOT;
            end
            OP_FDIG: begin
                want      = 1'b1;
                emit_char = CH_ZERO + CHAR_W'(prod[FRAC_BITS+DIGIT_W-1:FRAC_BITS]);
            end
            OP_ACCEPT, OP_DABBLE, OP_POINT, OP_NOP: begin
                want      = 1'b0;
                emit_char = CH_ZERO;
            end
        endcase
    end

    assign emit      = want && slot_free;
    assign emit_last = (left_reg == LEN_W'(1));

    assign status.accept    = accept;
    assign status.emit      = emit;
    assign status.last      = emit_last;
    assign status.stall     = want && !slot_free;
    assign status.dptr_nz   = (dptr_reg != '0);
    assign status.frac_more = (fcnt_reg > CFG_W'(1));
    assign status.fw_zero   = (fw_reg == '0);

    always_ff @(posedge aclk) begin
        unique case (op)
            OP_ACCEPT: begin
                if (accept) begin
                    neg_reg   <= neg_in;
                    ipart_reg <= mag_in[VALUE_W-1:FRAC_BITS];
                    frac_reg  <= mag_in[FRAC_BITS-1:0];
                    iw_reg    <= iw_c;
                    fw_reg    <= fw_c;
                    left_reg  <= len_in;
                    for (int i = 0; i < BCD_DIGITS; i++) begin
                        bcd_reg[i] <= '0;
                    end
                end
            end
            OP_DABBLE: begin
                ipart_reg <= {ipart_reg[INT_W-2:0], 1'b0};
                for (int i = 0; i < BCD_DIGITS; i++) begin
                    bcd_reg[i] <= bcd_shift[i];
                end
            end
            OP_POINT: begin
                dptr_reg <= start_ptr;
                fcnt_reg <= fw_reg;
            end
            OP_SIGN, OP_DOT: begin
                if (emit) begin
                    left_reg <= left_reg - LEN_W'(1);
                end
            end
            OP_IDIG: begin
                if (emit) begin
                    left_reg <= left_reg - LEN_W'(1);
                    dptr_reg <= dptr_reg - DPTR_W'(1);
                end
            end
            OP_FDIG: begin
                if (emit) begin
                    left_reg <= left_reg - LEN_W'(1);
                    frac_reg <= prod[FRAC_BITS-1:0];
                    fcnt_reg <= fcnt_reg - CFG_W'(1);
                end
            end
            OP_NOP: begin
            end
        endcase
    end

endmodule

FILE: design/fixed_to_decimal_ascii.sv
// Top level: configuration registers, output register and the sequencer/datapath pair.
// Depends on ftda_pkg, ftda_seq and ftda_dp.
`timescale 1ns / 1ps

// Converts one signed fixed-point word (56 bits, 24 fraction bits) into an ASCII string sent
// one character per output word, m_tlast on the final one: optional '-', the integer part
// zero padded to integer_width digits, then '.' and fraction_width truncated fraction
// digits when fraction_width is nonzero; the string is clipped to sign + integer_width
// (+ 1 + fraction_width) characters, integer_width being taken as 1 to 12 and fraction_width
// as at most 8. A small microcode program runs the conversion: it takes the input, runs
// shift-add-3 over the 32 integer bits (one integer bit per cycle), finds the leading digit,
// then sends the characters, holding while the output side stalls, with an idle step in
// place of a missing sign. The string is at most 22 characters long. The next word is
// taken only after the last character of the current one has entered the output register.
// Write configuration only while the block is idle.
module fixed_to_decimal_ascii
    import ftda_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,     // [55:0] value
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CHAR_W-1:0]   m_tdata,     // [7:0] character
    output logic                m_tlast,
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wr_data
);

    logic [CFG_W-1:0]  int_width_reg;
    logic [CFG_W-1:0]  frac_width_reg;
    logic              m_tvalid_reg;
    logic [CHAR_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;

    logic              slot_free;
    logic              emit;
    logic [CHAR_W-1:0] emit_char;
    logic              emit_last;
    logic [OP_W-1:0]   op;
    logic              dp_ready;
    dp_status_t        status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_width_reg  <= CFG_W'(1);
            frac_width_reg <= CFG_W'(2);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_INT_WIDTH:  int_width_reg  <= cfg_wr_data;
                REG_FRAC_WIDTH: frac_width_reg <= cfg_wr_data;
            endcase
        end
    end

    ftda_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .op      (op)
    );

    ftda_dp u_dp (
        .aclk       (aclk),
        .op         (op),
        .s_tvalid   (s_tvalid),
        .s_tready   (dp_ready),
        .s_tdata    (s_tdata),
        .int_width  (int_width_reg),
        .frac_width (frac_width_reg),
        .slot_free  (slot_free),
        .emit       (emit),
        .emit_char  (emit_char),
        .emit_last  (emit_last),
        .status     (status)
    );

    // no word is taken while in reset
    assign s_tready = dp_ready && aresetn;

    // output register: refilled in the cycle it drains
    assign slot_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (slot_free) begin
            m_tvalid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && emit) begin
            m_tdata_reg <= emit_char;
            m_tlast_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
